@@ hdl/mahb_pkg.sv @@
// ----------------------------------------------------------------------------
// mahb_pkg: shared types and constants of the audio history buffer
// Item structs, status and request codes, lane controls, divide table.
// ----------------------------------------------------------------------------
package mahb_pkg;

  localparam int CAPACITY     = 4096;
  localparam int ADDR_W       = $clog2(CAPACITY);
  localparam int COUNT_W      = ADDR_W + 1;
  localparam int MAX_CHANNELS = 8;
  localparam int CHAN_W       = 4;
  localparam int SAMPLE_BITS  = 24;
  localparam int FRAME_W      = MAX_CHANNELS * SAMPLE_BITS;
  localparam int SUM_W        = SAMPLE_BITS + 3;
  localparam int RECIP_SHIFT  = 30;
  localparam int RECIP_W      = RECIP_SHIFT + 1;
  localparam int PROD_W       = SUM_W + RECIP_W;
  localparam int LANE_W       = 3;

  localparam logic              REQ_APPEND   = 1'b0;
  localparam logic              REQ_READ     = 1'b1;
  localparam logic [CHAN_W-1:0] ALL_CHANNELS = CHAN_W'(MAX_CHANNELS);

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_CHAN = 2'd1;
  localparam logic [1:0] ST_BAD_WIN  = 2'd2;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]       sum_t;

  typedef struct packed {
    logic                 req_type;
    sample_t              sample_ch0;
    sample_t              sample_ch1;
    sample_t              sample_ch2;
    sample_t              sample_ch3;
    sample_t              sample_ch4;
    sample_t              sample_ch5;
    sample_t              sample_ch6;
    sample_t              sample_ch7;
    logic [COUNT_W-1:0]   read_count;
    logic [ADDR_W-1:0]    read_offset;
    logic [CHAN_W-1:0]    read_channel;
  } mahb_in_t;

  typedef struct packed {
    logic [1:0] status;
    sample_t    sample_value;
    logic       window_filled;
  } mahb_out_t;

  // Stage enables from the read sequencer to lanes and merge
  typedef struct packed {
    logic lane_en;
    logic pair_en;
    logic total_en;
    logic mul_en;
  } mahb_ctl_t;

  // ceil(2^RECIP_SHIFT / n): exact truncating quotient for |sum| < 2^27
  function automatic logic [RECIP_W-1:0] mahb_recip(input logic [CHAN_W-1:0] n);
    logic [RECIP_W-1:0] r;
    unique case (n)
      4'd2:    r = RECIP_W'(536870912);
      4'd3:    r = RECIP_W'(357913942);
      4'd4:    r = RECIP_W'(268435456);
      4'd5:    r = RECIP_W'(214748365);
      4'd6:    r = RECIP_W'(178956971);
      4'd7:    r = RECIP_W'(153391690);
      4'd8:    r = RECIP_W'(134217728);
      default: r = RECIP_W'(1073741824);
    endcase
    return r;
  endfunction

endpackage

@@ hdl/mahb_lane.sv @@
// ----------------------------------------------------------------------------
// mahb_lane: one channel lane
// Masks the lane's sample by the active channel count and picks it when the
// read names this channel.
// ----------------------------------------------------------------------------
module mahb_lane
  import mahb_pkg::*;
(
  input  logic              clk,
  input  mahb_ctl_t         ctl,
  input  logic [LANE_W-1:0] lane_id,
  input  logic [CHAN_W-1:0] num_channels,
  input  logic [CHAN_W-1:0] read_channel,
  input  sample_t           sample,
  output sum_t              term,
  output sample_t           pick
);

  logic active;
  logic chosen;

  assign active = {1'b0, lane_id} < num_channels;
  assign chosen = read_channel == {1'b0, lane_id};

  always_ff @(posedge clk) begin
    if (ctl.lane_en) begin
      term <= active ? SUM_W'(sample) : '0;
      pick <= chosen ? sample : '0;
    end
  end

endmodule

@@ hdl/mahb_merge.sv @@
// ----------------------------------------------------------------------------
// mahb_merge: combine lane results
// Registered adder tree, magnitude, reciprocal multiply for the channel
// average, and the single-channel pick.
// ----------------------------------------------------------------------------
module mahb_merge
  import mahb_pkg::*;
(
  input  logic              clk,
  input  mahb_ctl_t         ctl,
  input  logic [CHAN_W-1:0] num_channels,
  input  sum_t              terms [MAX_CHANNELS],
  input  sample_t           picks [MAX_CHANNELS],
  output sample_t           avg_value,
  output sample_t           pick_value
);

  localparam int NPAIR = MAX_CHANNELS / 2;

  sum_t               pair [NPAIR];
  sum_t               total;
  logic               neg;
  logic [SUM_W-1:0]   mag;
  logic [RECIP_W-1:0] recip;
  logic [PROD_W-1:0]  prod;
  sample_t            pick_or;
  logic [SUM_W-1:0]   quot;
  logic [SUM_W-1:0]   signed_quot;

  always_comb begin
    pick_or = '0;
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      pick_or = pick_or | picks[i];
    end
    total = '0;
    for (int k = 0; k < NPAIR; k++) begin
      total = total + pair[k];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pair_en) begin
      for (int k = 0; k < NPAIR; k++) begin
        pair[k] <= terms[2*k] + terms[2*k+1];
      end
      pick_value <= pick_or;
    end
    if (ctl.total_en) begin
      neg   <= total[SUM_W-1];
      mag   <= total[SUM_W-1] ? SUM_W'(-total) : SUM_W'(total);
      recip <= mahb_recip(num_channels);
    end
    if (ctl.mul_en) begin
      prod <= PROD_W'(mag) * PROD_W'(recip);
    end
  end

  // Truncate toward zero: divide the magnitude, then restore the sign
  assign quot        = prod[RECIP_SHIFT +: SUM_W];
  assign signed_quot = neg ? (~quot + 1'b1) : quot;
  assign avg_value   = signed_quot[SAMPLE_BITS-1:0];

endmodule

@@ hdl/multichannel_audio_history_buffer.sv @@
// ----------------------------------------------------------------------------
// multichannel_audio_history_buffer: circular store of multichannel frames
// Appends frames of up to eight Q1.23 samples and answers reads of one
// channel, or the channel average, at a point in the latest window.
// ----------------------------------------------------------------------------
// An append item is taken at acceptance and gives no result, so appends
// can follow each other on every clock while no read is in flight. A read
// item loads its frame from memory at acceptance and then keeps in_ready
// low while it passes each stage behind the memory read (lane register,
// pair adders, total and magnitude, reciprocal multiply, output load); the
// next item can be taken only after its result is loaded. It waits longer
// in the last stage if the previous result has not been taken. The path
// length is set by the 192-bit frame memory's registered read and the
// 27 x 31 reciprocal multiply that forms the channel average. Status and
// window_filled are decided at acceptance; a bad channel wins over a bad
// window, and a result with nonzero status, or with too few frames written,
// carries a zero sample. Writing num_channels (0 acts as 1, above 8 acts as
// 8) clears the write position and fill count; write it only while the
// block is idle. The frame memory has no reset: reads only reach frames
// written since the last clear.
module multichannel_audio_history_buffer
  import mahb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mahb_in_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output mahb_out_t         out_data,
  input  logic              cfg_we,
  input  logic [CHAN_W-1:0] cfg_data
);

  // Read sequencer phases
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_LANE  = 3'd1;
  localparam logic [2:0] PH_PAIR  = 3'd2;
  localparam logic [2:0] PH_TOTAL = 3'd3;
  localparam logic [2:0] PH_MUL   = 3'd4;
  localparam logic [2:0] PH_DONE  = 3'd5;

  logic [2:0]         phase;
  logic [2:0]         phase_next;
  logic [ADDR_W-1:0]  write_position;
  logic [COUNT_W-1:0] frames_filled;
  logic [CHAN_W-1:0]  num_channels;

  logic [FRAME_W-1:0] mem [CAPACITY];
  logic [FRAME_W-1:0] rd_data;

  // Item held for the read in flight
  logic [1:0]         item_status;
  logic               item_enough;
  logic               item_all;
  logic [CHAN_W-1:0]  item_chan;

  logic               accept;
  logic               take_append;
  logic               take_read;
  logic               done_load;
  logic               chan_bad;
  logic               win_bad;
  logic               short_fill;
  logic [ADDR_W-1:0]  rd_idx;
  logic [FRAME_W-1:0] wr_frame;
  logic [CHAN_W-1:0]  cfg_clamped;
  mahb_ctl_t          ctl;
  sum_t               terms [MAX_CHANNELS];
  sample_t            picks [MAX_CHANNELS];
  sample_t            avg_value;
  sample_t            pick_value;

  assign in_ready    = phase == PH_IDLE;
  assign accept      = in_valid && in_ready;
  assign take_append = accept && in_data.req_type == REQ_APPEND;
  assign take_read   = accept && in_data.req_type == REQ_READ;
  assign done_load   = phase == PH_DONE && (!out_valid || out_ready);

  // Classify the read at acceptance; the checks are ordered as stated above
  assign chan_bad   = in_data.read_channel != ALL_CHANNELS &&
                      in_data.read_channel >= num_channels;
  assign win_bad    = in_data.read_count == '0 ||
                      in_data.read_count > COUNT_W'(CAPACITY) ||
                      {1'b0, in_data.read_offset} >= in_data.read_count;
  assign short_fill = frames_filled < in_data.read_count;

  // Oldest frame of the window sits read_count frames behind the write point
  assign rd_idx = write_position - in_data.read_count[ADDR_W-1:0] + in_data.read_offset;

  assign wr_frame = {in_data.sample_ch7, in_data.sample_ch6, in_data.sample_ch5,
                     in_data.sample_ch4, in_data.sample_ch3, in_data.sample_ch2,
                     in_data.sample_ch1, in_data.sample_ch0};

  assign cfg_clamped = (cfg_data == '0) ? CHAN_W'(1) :
                       (cfg_data > CHAN_W'(MAX_CHANNELS)) ? CHAN_W'(MAX_CHANNELS) :
                       cfg_data;

  assign ctl.lane_en  = phase == PH_LANE;
  assign ctl.pair_en  = phase == PH_PAIR;
  assign ctl.total_en = phase == PH_TOTAL;
  assign ctl.mul_en   = phase == PH_MUL;

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_IDLE:  if (take_read) phase_next = PH_LANE;
      PH_LANE:  phase_next = PH_PAIR;
      PH_PAIR:  phase_next = PH_TOTAL;
      PH_TOTAL: phase_next = PH_MUL;
      PH_MUL:   phase_next = PH_DONE;
      PH_DONE:  if (done_load) phase_next = PH_IDLE;
      default:  phase_next = PH_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      write_position <= '0;
      frames_filled  <= '0;
      num_channels   <= CHAN_W'(1);
      out_valid      <= 1'b0;
    end else begin
      phase <= phase_next;
      if (cfg_we) begin
        num_channels   <= cfg_clamped;
        write_position <= '0;
        frames_filled  <= '0;
      end else if (take_append) begin
        write_position <= write_position + 1'b1;
        if (frames_filled != COUNT_W'(CAPACITY)) begin
          frames_filled <= frames_filled + 1'b1;
        end
      end
      if (done_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Frame memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (take_append) begin
      mem[write_position] <= wr_frame;
    end
    if (take_read) begin
      rd_data <= mem[rd_idx];
    end
  end

  // Hold the read's verdict while the data path runs
  always_ff @(posedge clk) begin
    if (take_read) begin
      item_chan <= in_data.read_channel;
      item_all  <= in_data.read_channel == ALL_CHANNELS;
      priority if (chan_bad) begin
        item_status <= ST_BAD_CHAN;
        item_enough <= 1'b0;
      end else if (win_bad) begin
        item_status <= ST_BAD_WIN;
        item_enough <= 1'b0;
      end else begin
        item_status <= ST_OK;
        item_enough <= !short_fill;
      end
    end
  end

  for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_lane
    mahb_lane u_lane (
      .clk          (clk),
      .ctl          (ctl),
      .lane_id      (LANE_W'(i)),
      .num_channels (num_channels),
      .read_channel (item_chan),
      .sample       (rd_data[i*SAMPLE_BITS +: SAMPLE_BITS]),
      .term         (terms[i]),
      .pick         (picks[i])
    );
  end

  mahb_merge u_merge (
    .clk          (clk),
    .ctl          (ctl),
    .num_channels (num_channels),
    .terms        (terms),
    .picks        (picks),
    .avg_value    (avg_value),
    .pick_value   (pick_value)
  );

  // Output register: drop the sample unless the read found its frame
  always_ff @(posedge clk) begin
    if (done_load) begin
      out_data.status        <= item_status;
      out_data.window_filled <= item_enough;
      if (!item_enough) begin
        out_data.sample_value <= '0;
      end else if (item_all) begin
        out_data.sample_value <= avg_value;
      end else begin
        out_data.sample_value <= pick_value;
      end
    end
  end

  a_read_starts: assert property (@(posedge clk) disable iff (rst)
    take_read |=> phase == PH_LANE)
    else $error("accepted read did not start the sequencer");

  a_append_advances: assert property (@(posedge clk) disable iff (rst)
    take_append && !cfg_we |=> write_position == $past(write_position) + 1'b1)
    else $error("write position did not advance after an append");

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    frames_filled <= COUNT_W'(CAPACITY))
    else $error("fill count beyond capacity");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_OK |->
      out_data.sample_value == '0 && !out_data.window_filled)
    else $error("error result carries data");

  a_load_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(phase) == PH_DONE)
    else $error("result appeared without a finished read");

endmodule
